@@ hw/rtl/tga_pkg.sv @@
// Shared types, register indexes and helpers for the TGA RLE pixel decoder.
// No dependencies; imported by tga_decode and tga_rle_pixel_decoder.
package tga_pkg;

  // Configuration register indexes
  localparam logic [1:0] REG_PIXEL_FORMAT = 2'd0;
  localparam logic [1:0] REG_RLE_ENABLE   = 2'd1;
  localparam logic [1:0] REG_PIXEL_COUNT  = 2'd2;

  // Pixel formats
  localparam logic [1:0] FMT_GRAY8  = 2'd0;
  localparam logic [1:0] FMT_BGR24  = 2'd1;
  localparam logic [1:0] FMT_BGRA32 = 2'd2;

  // Packet phase codes
  localparam logic PH_HEADER = 1'b0;
  localparam logic PH_DATA   = 1'b1;

  localparam logic [7:0] HDR_RUN_BIT  = 8'h80;
  localparam logic [7:0] HDR_LEN_MASK = 8'h7F;

  typedef struct packed {
    logic [31:0] pixel_value;
    logic [7:0]  run_length;
    logic        image_end;
    logic        run_clipped;
  } result_t;

  // Bytes per pixel; the unused format code acts as 32-bit
  function automatic logic [2:0] bytes_per_pixel(input logic [1:0] fmt);
    logic [2:0] bpp;
    unique case (fmt)
      FMT_GRAY8: bpp = 3'd1;
      FMT_BGR24: bpp = 3'd3;
      default:   bpp = 3'd4;
    endcase
    return bpp;
  endfunction

endpackage

@@ hw/rtl/tga_in_reg.sv @@
// Input pipeline register for the TGA RLE pixel decoder: holds one byte.
// No dependencies.
module tga_in_reg (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data,
  output logic       hold_valid,
  output logic [7:0] hold_data,
  input  logic       advance
);

  logic valid;
  logic [7:0] data;

  // Take a new byte when empty or when the held one moves on
  assign in_ready   = !valid || advance;
  assign hold_valid = valid;
  assign hold_data  = data;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data <= in_data;
    end
  end

endmodule

@@ hw/rtl/tga_decode.sv @@
// Decode stage of the TGA RLE pixel decoder: configuration registers,
// packet/pixel state, and the per-byte next-state and result logic. Uses tga_pkg.
module tga_decode
  import tga_pkg::*;
#(
  parameter int COUNT_BITS = 29
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COUNT_BITS-1:0] cfg_data,
  input  logic                  advance,
  input  logic [7:0]            byte_in,
  output logic                  res_valid,
  output result_t               res
);

  logic [1:0]            pixel_format;
  logic                  rle_enable;
  logic [COUNT_BITS-1:0] pixel_count;

  logic                  packet_phase, packet_phase_next;
  logic [1:0]            byte_in_pixel, byte_in_pixel_next;
  logic [31:0]           pixel_gather, pixel_gather_next;
  logic [7:0]            packet_remaining, packet_remaining_next;
  logic                  packet_is_run, packet_is_run_next;
  logic [COUNT_BITS-1:0] pixels_done, pixels_done_next;

  logic [2:0]          bpp;
  logic [31:0]         gather_base;
  logic [7:0]          rem, run, run_cut, left_after;
  logic [COUNT_BITS:0] total, done_ext, need;
  logic                clip, img_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= FMT_GRAY8;
      rle_enable   <= 1'b1;
      pixel_count  <= COUNT_BITS'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PIXEL_FORMAT: pixel_format <= cfg_data[1:0];
        REG_RLE_ENABLE:   rle_enable   <= cfg_data[0];
        REG_PIXEL_COUNT:  pixel_count  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    bpp         = bytes_per_pixel(pixel_format);
    gather_base = (byte_in_pixel == 2'd0) ? 32'd0 : pixel_gather;
    total       = {pixel_count == '0, pixel_count};
    done_ext    = {1'b0, pixels_done};
    need        = (done_ext < total) ? (total - done_ext) : (COUNT_BITS+1)'(1);
    rem         = (packet_remaining == 8'd0) ? 8'd1 : packet_remaining;

    if (rle_enable && packet_is_run) begin
      run        = rem;
      left_after = 8'd0;
    end else if (rle_enable) begin
      run        = 8'd1;
      left_after = rem - 8'd1;
    end else begin
      run        = 8'd1;
      left_after = 8'd0;
    end

    clip    = (COUNT_BITS+1)'(run) > need;
    run_cut = clip ? need[7:0] : run;
    img_end = (COUNT_BITS+1)'(run_cut) == need;

    packet_phase_next     = packet_phase;
    byte_in_pixel_next    = byte_in_pixel;
    pixel_gather_next     = pixel_gather;
    packet_remaining_next = packet_remaining;
    packet_is_run_next    = packet_is_run;
    pixels_done_next      = pixels_done;
    res_valid             = 1'b0;

    res.pixel_value = 32'd0;
    res.run_length  = run_cut;
    res.image_end   = img_end;
    res.run_clipped = clip || (img_end && left_after != 8'd0);

    if (rle_enable && packet_phase == PH_HEADER) begin
      // Packet header: latch kind and length, restart pixel assembly
      packet_is_run_next    = (byte_in & HDR_RUN_BIT) != 8'd0;
      packet_remaining_next = (byte_in & HDR_LEN_MASK) + 8'd1;
      packet_phase_next     = PH_DATA;
      byte_in_pixel_next    = 2'd0;
      pixel_gather_next     = 32'd0;
    end else begin
      pixel_gather_next = gather_base | (32'(byte_in) << {byte_in_pixel, 3'b000});
      if ({1'b0, byte_in_pixel} + 3'd1 < bpp) begin
        byte_in_pixel_next = byte_in_pixel + 2'd1;
      end else begin
        byte_in_pixel_next = 2'd0;
        res_valid          = 1'b1;
        if (bpp == 3'd1) begin
          res.pixel_value = {24'd0, pixel_gather_next[7:0]};
        end else begin
          res.pixel_value = {(bpp == 3'd4) ? pixel_gather_next[31:24] : 8'd0,
                             pixel_gather_next[7:0], pixel_gather_next[15:8],
                             pixel_gather_next[23:16]};
        end
        if (img_end) begin
          pixels_done_next      = '0;
          packet_phase_next     = PH_HEADER;
          packet_remaining_next = 8'd0;
        end else begin
          pixels_done_next = pixels_done + COUNT_BITS'(run_cut);
          if (rle_enable) begin
            packet_remaining_next = left_after;
            if (left_after == 8'd0) packet_phase_next = PH_HEADER;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_phase     <= PH_HEADER;
      byte_in_pixel    <= 2'd0;
      pixel_gather     <= 32'd0;
      packet_remaining <= 8'd0;
      packet_is_run    <= 1'b0;
      pixels_done      <= '0;
    end else if (advance) begin
      packet_phase     <= packet_phase_next;
      byte_in_pixel    <= byte_in_pixel_next;
      pixel_gather     <= pixel_gather_next;
      packet_remaining <= packet_remaining_next;
      packet_is_run    <= packet_is_run_next;
      pixels_done      <= pixels_done_next;
    end
  end

endmodule

@@ hw/rtl/tga_rle_pixel_decoder.sv @@
// Top level of the TGA RLE pixel decoder: stream ports, output register, assertions.
// Depends on tga_pkg, tga_in_reg and tga_decode.
//
// Decodes TGA pixel-data bytes (the stream after the file header), one byte
// per transfer on the s_ side, at one byte per clock sustained while m_ accepts. Each byte
// passes an input register, then a single decode step updates the packet and
// pixel state and, when a pixel completes, loads the output register, so a
// byte's result passes both the input register and the output register.
// Header bytes and partial-pixel bytes give no result. Each result carries
// the pixel (red in byte 0, alpha in byte 3 for 32-bit, upper bytes zero for
// narrower formats), the number of image pixels it stands for (1..128),
// tlast when it completes the image, and tuser when a packet was cut at the
// image end. Backpressure on m_ stalls the input only once both registers
// are full. Write configuration only while the block is idle; pixel_count 0
// means 2^COUNT_BITS pixels.
module tga_rle_pixel_decoder
  import tga_pkg::*;
#(
  parameter int COUNT_BITS = 29
) (
  input  logic                  clk,
  input  logic                  rst,
  // Configuration write port
  input  logic                  cfg_we,
  input  logic [1:0]            cfg_index,
  input  logic [COUNT_BITS-1:0] cfg_data,
  // Input stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] data_byte
  // Output stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [39:0]           m_tdata,   // [31:0] pixel_value, [39:32] run_length
  output logic                  m_tlast,   // image_end
  output logic                  m_tuser    // [0] run_clipped
);

  logic    hold_valid;
  logic [7:0] hold_data;
  logic    advance;
  logic    res_valid;
  result_t res;
  result_t out_res;
  logic    out_valid;

  // Move the held byte on when the output register is free or draining
  assign advance = hold_valid && (!out_valid || m_tready);

  tga_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_data    (s_tdata),
    .hold_valid (hold_valid),
    .hold_data  (hold_data),
    .advance    (advance)
  );

  tga_decode #(
    .COUNT_BITS (COUNT_BITS)
  ) u_dec (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .advance   (advance),
    .byte_in   (hold_data),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register: load a result, otherwise drop valid once transferred
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && res_valid) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_res.run_length, out_res.pixel_value};
  assign m_tlast  = out_res.image_end;
  assign m_tuser  = out_res.run_clipped;

  // A run always stands for at least one pixel and at most 128
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (m_tdata[39:32] != 8'd0 && m_tdata[39:32] <= 8'd128))
    else $error("run_length out of range");

  // A packet is only cut at the end of an image
  a_clip_at_end: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser) |-> m_tlast)
    else $error("clipped result without image end");

  // With the output register empty the input side never stalls
  a_no_false_stall: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled while output empty");

  // A held byte advances at once while the output is being drained
  a_drain_advance: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tready) |-> s_tready)
    else $error("input stalled while output drains");

endmodule
